// ===== design/mdu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mdu_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned OpW      = 3;
  localparam int unsigned DivSteps = 32;
  localparam int unsigned CntW     = 5;

  typedef enum logic [OpW-1:0] {
    OP_MULT  = 3'd0,
    OP_MULTU = 3'd1,
    OP_DIV   = 3'd2,
    OP_DIVU  = 3'd3,
    OP_MTHI  = 3'd4,
    OP_MTLO  = 3'd5
  } mdu_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIX
  } mdu_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic commit;
  } mdu_cmd_t;

endpackage

`default_nettype wire

// ===== design/mdu_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mdu_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [mdu_pkg::OpW-1:0]  in_op_i,
  input  logic                     out_ready_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  output mdu_pkg::mdu_cmd_t        cmd_o
);
  import mdu_pkg::*;

  mdu_state_e      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            can_write;
  logic            last_step;

  assign can_write = !out_valid_q || out_ready_i;
  assign last_step = (cnt_q == CntW'(DivSteps - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_op_i)
            OP_MULT, OP_MULTU: state_d = ST_MUL;
            OP_DIV, OP_DIVU:   state_d = ST_DIV;
            default:           state_d = ST_FIX;
          endcase
        end
      end
      ST_MUL: state_d = ST_FIX;
      ST_DIV: begin
        if (last_step) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        if (can_write) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        cnt_d      = '0;
      end
      ST_MUL: cmd_o.mul = 1'b1;
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CntW'(1);
      end
      ST_FIX: begin
        cmd_o.commit = can_write;
        if (can_write) begin
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== design/mdu_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mdu_dpath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mdu_pkg::mdu_cmd_t         cmd_i,
  input  logic [mdu_pkg::OpW-1:0]   in_op_i,
  input  logic [mdu_pkg::WordW-1:0] in_rs_value_i,
  input  logic [mdu_pkg::WordW-1:0] in_rt_value_i,
  output logic [mdu_pkg::WordW-1:0] hi_o,
  output logic [mdu_pkg::WordW-1:0] lo_o
);
  import mdu_pkg::*;

  logic [OpW-1:0]     op_q;
  logic [WordW-1:0]   rem_q, rem_d;
  logic [WordW-1:0]   quo_q, quo_d;
  logic [WordW-1:0]   dvs_q;
  logic               neg_res_q, neg_rem_q;
  logic [WordW-1:0]   hi_q, hi_d;
  logic [WordW-1:0]   lo_q, lo_d;

  logic               is_signed;
  logic [WordW-1:0]   mag_a, mag_b;
  logic [WordW:0]     shifted, diff;
  logic [2*WordW-1:0] prod, prod_neg;

  assign is_signed = (in_op_i == OP_MULT) || (in_op_i == OP_DIV);
  assign mag_a = (is_signed && in_rs_value_i[WordW-1]) ? (WordW'(0) - in_rs_value_i)
                                                        : in_rs_value_i;
  assign mag_b = (is_signed && in_rt_value_i[WordW-1]) ? (WordW'(0) - in_rt_value_i)
                                                        : in_rt_value_i;

  // One restoring division step: one quotient bit per cycle.
  assign shifted  = {rem_q, quo_q[WordW-1]};
  assign diff     = shifted - {1'b0, dvs_q};
  assign prod     = {rem_q, quo_q};
  assign prod_neg = (2*WordW)'(0) - prod;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (cmd_i.load) begin
      rem_d = '0;
      quo_d = mag_a;
    end else if (cmd_i.mul) begin
      {rem_d, quo_d} = (2*WordW)'(quo_q) * (2*WordW)'(dvs_q);
    end else if (cmd_i.div_step) begin
      if (!diff[WordW]) begin
        rem_d = diff[WordW-1:0];
        quo_d = {quo_q[WordW-2:0], 1'b1};
      end else begin
        rem_d = shifted[WordW-1:0];
        quo_d = {quo_q[WordW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    hi_d = hi_q;
    lo_d = lo_q;
    if (cmd_i.commit) begin
      unique case (op_q)
        OP_MULT:  {hi_d, lo_d} = neg_res_q ? prod_neg : prod;
        OP_MULTU: {hi_d, lo_d} = prod;
        OP_DIV: begin
          lo_d = neg_res_q ? (WordW'(0) - quo_q) : quo_q;
          hi_d = neg_rem_q ? (WordW'(0) - rem_q) : rem_q;
        end
        OP_DIVU: begin
          lo_d = quo_q;
          hi_d = rem_q;
        end
        OP_MTHI:  hi_d = quo_q;
        OP_MTLO:  lo_d = quo_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (cmd_i.load) begin
      op_q      <= in_op_i;
      dvs_q     <= mag_b;
      neg_res_q <= is_signed && (in_rs_value_i[WordW-1] ^ in_rt_value_i[WordW-1]);
      neg_rem_q <= is_signed && in_rs_value_i[WordW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q <= '0;
      lo_q <= '0;
    end else begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign hi_o = hi_q;
  assign lo_o = lo_q;

endmodule

`default_nettype wire

// ===== design/multiply_divide_unit_hi_lo_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Multiply/divide unit that holds the HI and LO words and reports both after every
// operation. One operation is in flight at a time. A multiply steps through loading the
// magnitudes, the 32x32 multiplier, and the sign fix and write-back. A divide loads the
// magnitudes, runs the restoring divider, which produces one quotient bit per cycle for
// all 32 quotient bits, and then does the sign fix and write-back. Moves and unused
// operation codes go from the load straight to the write-back. The HI and LO words serve
// as the output register, so a new operation is accepted while a result beat still
// waits; that operation stalls before its write-back until the waiting beat is taken.
module multiply_divide_unit_hi_lo_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [mdu_pkg::OpW-1:0]   in_op_i,
  input  logic [mdu_pkg::WordW-1:0] in_rs_value_i,
  input  logic [mdu_pkg::WordW-1:0] in_rt_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [mdu_pkg::WordW-1:0] out_hi_result_o,
  output logic [mdu_pkg::WordW-1:0] out_lo_result_o
);
  import mdu_pkg::*;

  mdu_cmd_t cmd;

  mdu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_op_i),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  mdu_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .in_op_i       (in_op_i),
    .in_rs_value_i (in_rs_value_i),
    .in_rt_value_i (in_rt_value_i),
    .hi_o          (out_hi_result_o),
    .lo_o          (out_lo_result_o)
  );

endmodule

`default_nettype wire

// ===== verif/multiply_divide_unit_hi_lo_top_tb.sv =====
`timescale 1ns / 1ps

module multiply_divide_unit_hi_lo_top_tb;
  import mdu_pkg::*;

  localparam int unsigned           ClkPeriod     = 8;
  localparam int unsigned           WatchdogLimit = 3000;
  localparam int unsigned           SettleCycles  = 50;
  localparam logic [OpW-1:0]        OP_RSVD6      = 3'd6;
  localparam logic [OpW-1:0]        OP_RSVD7      = 3'd7;
  localparam logic [WordW-1:0]      SIGN_WORD     = 32'h8000_0000;
  localparam logic [WordW-1:0]      ALL_ONES      = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [WordW-1:0] hi;
    logic [WordW-1:0] lo;
  } hilo_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [OpW-1:0]   in_op_i;
  logic [WordW-1:0] in_rs_value_i;
  logic [WordW-1:0] in_rt_value_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [WordW-1:0] out_hi_result_o;
  logic [WordW-1:0] out_lo_result_o;

  logic [WordW-1:0] hi_model;
  logic [WordW-1:0] lo_model;
  hilo_t            hilo_expect_q[$];
  int               fail_count;
  int               idle_cycles;
  int               rx_hold_cycles;
  int               rx_stall_left;
  bit               rx_random_stalls;
  bit               tx_random_gaps;

  multiply_divide_unit_hi_lo_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_op_i        (in_op_i),
    .in_rs_value_i  (in_rs_value_i),
    .in_rt_value_i  (in_rt_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_hi_result_o(out_hi_result_o),
    .out_lo_result_o(out_lo_result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  function automatic void apply_hilo_op(input logic [OpW-1:0] op, input logic [WordW-1:0] a,
                                        input logic [WordW-1:0] b);
    logic [2*WordW-1:0] prod;
    logic [WordW-1:0]   mag_a;
    logic [WordW-1:0]   mag_b;
    logic [WordW-1:0]   quo;
    logic [WordW-1:0]   rem;
    case (op)
      OP_MULT: begin
        prod = {{WordW{a[WordW-1]}}, a} * {{WordW{b[WordW-1]}}, b};
        {hi_model, lo_model} = prod;
      end
      OP_MULTU: begin
        prod = {{WordW{1'b0}}, a} * {{WordW{1'b0}}, b};
        {hi_model, lo_model} = prod;
      end
      OP_DIV: begin
        if (b == '0) begin
          lo_model = a[WordW-1] ? 32'd1 : ALL_ONES;
          hi_model = a;
        end else if (a == SIGN_WORD && b == ALL_ONES) begin
          lo_model = SIGN_WORD;
          hi_model = '0;
        end else begin
          mag_a    = a[WordW-1] ? (32'd0 - a) : a;
          mag_b    = b[WordW-1] ? (32'd0 - b) : b;
          quo      = mag_a / mag_b;
          rem      = mag_a % mag_b;
          lo_model = (a[WordW-1] ^ b[WordW-1]) ? (32'd0 - quo) : quo;
          hi_model = a[WordW-1] ? (32'd0 - rem) : rem;
        end
      end
      OP_DIVU: begin
        if (b == '0) begin
          lo_model = ALL_ONES;
          hi_model = a;
        end else begin
          lo_model = a / b;
          hi_model = a % b;
        end
      end
      OP_MTHI: hi_model = a;
      OP_MTLO: lo_model = a;
      default: ;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!tx_random_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0:       return '0;
          1:       return 32'd1;
          2:       return 32'h7FFF_FFFF;
          3:       return SIGN_WORD;
          4:       return ALL_ONES;
          default: return 32'h8000_0001;
        endcase
      end
      1:       return $urandom_range(0, 15);
      2:       return 32'd0 - $urandom_range(1, 15);
      3:       return $urandom() >> $urandom_range(1, 31);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [OpW-1:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return OP_MULT;
    if (r < 40) return OP_MULTU;
    if (r < 60) return OP_DIV;
    if (r < 80) return OP_DIVU;
    if (r < 88) return OP_MTHI;
    if (r < 96) return OP_MTLO;
    if (r < 98) return OP_RSVD6;
    return OP_RSVD7;
  endfunction

  task automatic send_op(input logic [OpW-1:0] op, input logic [WordW-1:0] a,
                         input logic [WordW-1:0] b, input int unsigned gap);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    in_op_i       <= op;
    in_rs_value_i <= a;
    in_rt_value_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    apply_hilo_op(op, a, b);
    hilo_expect_q.push_back('{hi: hi_model, lo: lo_model});
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_for_drain();
    while (hilo_expect_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic test_multiply_extremes();
    send_op(OP_MULT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, pick_gap());
    send_op(OP_MULT, SIGN_WORD, SIGN_WORD, pick_gap());
    send_op(OP_MULT, ALL_ONES, ALL_ONES, pick_gap());
    send_op(OP_MULT, SIGN_WORD, 32'h7FFF_FFFF, pick_gap());
    send_op(OP_MULTU, ALL_ONES, ALL_ONES, pick_gap());
    send_op(OP_MULTU, '0, ALL_ONES, pick_gap());
    send_op(OP_MULTU, SIGN_WORD, 32'd2, pick_gap());
    release_input();
  endtask

  task automatic test_divide_special_cases();
    send_op(OP_DIV, 32'd0 - 32'd7, 32'd2, pick_gap());
    send_op(OP_DIV, 32'd7, 32'd0 - 32'd2, pick_gap());
    send_op(OP_DIV, 32'd0 - 32'd7, 32'd0 - 32'd2, pick_gap());
    send_op(OP_DIV, 32'd5, '0, pick_gap());
    send_op(OP_DIV, 32'd0 - 32'd5, '0, pick_gap());
    send_op(OP_DIV, SIGN_WORD, ALL_ONES, pick_gap());
    send_op(OP_DIV, '0, 32'd5, pick_gap());
    send_op(OP_DIVU, ALL_ONES, 32'd1, pick_gap());
    send_op(OP_DIVU, 32'd5, 32'd7, pick_gap());
    send_op(OP_DIVU, 32'h1234_5678, '0, pick_gap());
    release_input();
  endtask

  task automatic test_moves_and_unused_ops();
    send_op(OP_MTHI, ALL_ONES, $urandom(), pick_gap());
    send_op(OP_MTLO, ALL_ONES, $urandom(), pick_gap());
    send_op(OP_RSVD6, $urandom(), $urandom(), pick_gap());
    send_op(OP_MTHI, '0, ALL_ONES, pick_gap());
    send_op(OP_RSVD7, ALL_ONES, ALL_ONES, pick_gap());
    release_input();
  endtask

  task automatic test_random_mix(input int unsigned count);
    logic [OpW-1:0]   op;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    for (int unsigned i = 0; i < count; i++) begin
      op = pick_op();
      a  = pick_word();
      b  = pick_word();
      if (op == OP_DIV && $urandom_range(0, 99) < 3) begin
        a = SIGN_WORD;
        b = ALL_ONES;
      end
      send_op(op, a, b, pick_gap());
    end
    release_input();
  endtask

  task automatic test_output_backpressure();
    rx_hold_cycles = 300;
    for (int unsigned i = 0; i < 8; i++) begin
      send_op(pick_op(), pick_word(), pick_word(), 0);
    end
    release_input();
  endtask

  task automatic test_sender_pause();
    for (int unsigned i = 0; i < 5; i++) begin
      send_op(pick_op(), pick_word(), pick_word(), pick_gap());
    end
    release_input();
    wait_for_drain();
    for (int unsigned i = 0; i < 5; i++) begin
      send_op(pick_op(), pick_word(), pick_word(), pick_gap());
    end
    release_input();
  endtask

  initial begin
    int unsigned rx_pick;
    out_ready_i   = 1'b0;
    rx_stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        rx_hold_cycles--;
      end else if (rx_stall_left > 0) begin
        out_ready_i <= 1'b0;
        rx_stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (rx_random_stalls) begin
          rx_pick = $urandom_range(0, 99);
          if (rx_pick < 20) begin
            rx_stall_left = $urandom_range(1, 4);
          end else if (rx_pick < 22) begin
            rx_stall_left = $urandom_range(15, 60);
          end else begin
            rx_stall_left = 0;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    hilo_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (hilo_expect_q.size() == 0) begin
        $error("unexpected result beat: hi_result %h, lo_result %h", out_hi_result_o,
               out_lo_result_o);
        fail_count++;
      end else begin
        want = hilo_expect_q.pop_front();
        if (out_hi_result_o !== want.hi) begin
          $error("hi_result mismatch: expected %h, actual %h", want.hi, out_hi_result_o);
          fail_count++;
        end
        if (out_lo_result_o !== want.lo) begin
          $error("lo_result mismatch: expected %h, actual %h", want.lo, out_lo_result_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    fail_count       = 0;
    rx_hold_cycles   = 0;
    rx_random_stalls = 1'b1;
    tx_random_gaps   = 1'b1;
    hi_model         = '0;
    lo_model         = '0;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    in_op_i          = OP_MULT;
    in_rs_value_i    = '0;
    in_rt_value_i    = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_multiply_extremes();
    test_divide_special_cases();
    test_moves_and_unused_ops();
    test_output_backpressure();
    test_sender_pause();
    test_random_mix(450);
    rx_random_stalls = 1'b0;
    tx_random_gaps   = 1'b0;
    test_random_mix(100);
    rx_random_stalls = 1'b1;
    tx_random_gaps   = 1'b1;
    test_random_mix(20);

    wait_for_drain();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
